// ===== sv/pwt_pkg.sv =====
// Shared types and constants of the probe window tracker.
// Used by pwt_cell and probe_window_tracker_unit; no dependencies.
`default_nettype none
package pwt_pkg;

  localparam int SEQ_W = 32;
  localparam int CFG_W = 9;

  localparam logic [1:0] REQ_SENT   = 2'd0;
  localparam logic [1:0] REQ_ACK    = 2'd1;
  localparam logic [1:0] REQ_PERIOD = 2'd2;

  localparam logic CFG_INITIAL_WINDOW = 1'b0;
  localparam logic CFG_WINDOW_STEP    = 1'b1;

  localparam logic [CFG_W-1:0] RESET_WINDOW = 9'd10;
  localparam logic [CFG_W-1:0] RESET_STEP   = 9'd10;

  typedef struct packed {
    logic             busy;
    logic             searching;
    logic             found;
    logic [SEQ_W-1:0] key;
  } token_t;

endpackage
`default_nettype wire

// ===== sv/pwt_cell.sv =====
// One store slot of the tracker chain: holds a sequence number and its valid bit,
// and passes the ack search token to the next slot. Depends on pwt_pkg.
`default_nettype none
module pwt_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    clear,
  input  wire logic                    wr_en,
  input  wire logic [IDX_W-1:0]        wr_index,
  input  wire logic [pwt_pkg::SEQ_W-1:0] wr_seq,
  input  wire pwt_pkg::token_t         tok_in,
  output pwt_pkg::token_t              tok_out
);

  logic                     valid;
  logic [pwt_pkg::SEQ_W-1:0] seq;
  logic                     hit;
  logic                     stop;

  assign hit  = tok_in.busy && tok_in.searching && valid && (seq == tok_in.key);
  assign stop = tok_in.busy && tok_in.searching && valid && (seq > tok_in.key);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (wr_en && (wr_index == IDX_W'(INDEX))) begin
      valid <= 1'b1;
    end else if (hit) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_index == IDX_W'(INDEX))) begin
      seq <= wr_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.busy <= 1'b0;
    end else begin
      tok_out.busy <= tok_in.busy;
    end
    tok_out.key       <= tok_in.key;
    tok_out.searching <= tok_in.searching && !hit && !stop;
    tok_out.found     <= tok_in.found || hit;
  end

endmodule
`default_nettype wire

// ===== sv/probe_window_tracker_unit.sv =====
// Probe window tracker: store of outstanding probe sequence numbers as a chain of cells.
// Sent, period-end and unused requests: result in the cycle after acceptance, next item then.
// Ack: the search token walks the whole chain, result registered as it leaves the end;
// busy is high meanwhile. Results are strobed one cycle by result_valid; no stall.
// Synchronous reset clears the store valid bits, counters and window to its reset values.
// Depends on pwt_pkg and pwt_cell.
`default_nettype none
module probe_window_tracker_unit #(
  parameter int MAX_WINDOW  = 256,
  parameter int STORE_DEPTH = 512
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  req_type,
  input  wire logic [31:0]                 seq_num,
  input  wire logic [31:0]                 send_time,
  input  wire logic [31:0]                 event_time,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [pwt_pkg::CFG_W-1:0]   cfg_data,
  output logic                             result_valid,
  output logic [$clog2(MAX_WINDOW+1)-1:0]  window,
  output logic                             window_open,
  output logic [$clog2(STORE_DEPTH+1)-1:0] unacked,
  output logic [31:0]                      max_rtt,
  output logic                             report,
  output logic                             ack_matched,
  output logic                             overflow
);

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  pwt_pkg::token_t tok [STORE_DEPTH+1];

  logic [CNT_W-1:0]          write_index;
  logic [CNT_W-1:0]          held_count;
  logic [CNT_W-1:0]          sent_count;
  logic [WIN_W-1:0]          cur_window;
  logic [WIN_W-1:0]          ramp_window;
  logic [31:0]               worst_rtt;
  logic [31:0]               pend_rtt;
  logic [pwt_pkg::CFG_W-1:0] window_step;

  logic accept;
  logic wr_en;
  logic clear;
  logic scan_done;
  logic full;
  logic [31:0] grown;
  logic [31:0] cfg_ext;
  logic [WIN_W-1:0] clamped;
  logic [CNT_W-1:0] held_next;
  logic [CNT_W-1:0] sent_next;
  logic [WIN_W-1:0] ramp_next;
  logic [31:0]      worst_next;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (32'(write_index) >= 32'(STORE_DEPTH));
  assign wr_en     = accept && (req_type == pwt_pkg::REQ_SENT) && !full;
  assign clear     = accept && (req_type == pwt_pkg::REQ_PERIOD);
  assign scan_done = tok[STORE_DEPTH].busy;
  assign grown     = 32'(cur_window) + 32'(window_step);
  assign cfg_ext   = 32'(cfg_data);

  always_comb begin
    if (cfg_ext == 32'd0) begin
      clamped = WIN_W'(1);
    end else if (cfg_ext > 32'(MAX_WINDOW)) begin
      clamped = WIN_W'(MAX_WINDOW);
    end else begin
      clamped = WIN_W'(cfg_ext);
    end
  end

  always_comb begin
    held_next  = held_count;
    sent_next  = sent_count;
    ramp_next  = ramp_window;
    worst_next = worst_rtt;
    if (tok[STORE_DEPTH].found) begin
      if (held_count != '0) begin
        held_next = held_count - CNT_W'(1);
      end
      if (ramp_window < cur_window) begin
        if (sent_count != '0) begin
          sent_next = sent_count - CNT_W'(1);
        end
        ramp_next = ramp_window + WIN_W'(1);
      end else if (pend_rtt > worst_rtt) begin
        worst_next = pend_rtt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].busy <= 1'b0;
    end else begin
      tok[0].busy <= accept && (req_type == pwt_pkg::REQ_ACK);
    end
    tok[0].searching <= 1'b1;
    tok[0].found     <= 1'b0;
    tok[0].key       <= seq_num;
  end

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    pwt_cell #(
      .INDEX(i),
      .IDX_W(CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .wr_en   (wr_en),
      .wr_index(write_index),
      .wr_seq  (seq_num),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rtt <= event_time - send_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result_valid <= 1'b0;
      write_index  <= '0;
      held_count   <= '0;
      sent_count   <= '0;
      ramp_window  <= WIN_W'(1);
      worst_rtt    <= '0;
      cur_window   <= WIN_W'(pwt_pkg::RESET_WINDOW);
      window_step  <= pwt_pkg::RESET_STEP;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pwt_pkg::CFG_INITIAL_WINDOW) begin
          cur_window <= clamped;
        end else begin
          window_step <= cfg_data;
        end
      end
      if (scan_done) begin
        busy         <= 1'b0;
        result_valid <= 1'b1;
        held_count   <= held_next;
        sent_count   <= sent_next;
        ramp_window  <= ramp_next;
        worst_rtt    <= worst_next;
      end else if (accept) begin
        case (req_type)
          pwt_pkg::REQ_SENT: begin
            result_valid <= 1'b1;
            if (!full) begin
              write_index <= write_index + CNT_W'(1);
              held_count  <= held_count + CNT_W'(1);
              sent_count  <= sent_count + CNT_W'(1);
            end
          end
          pwt_pkg::REQ_ACK: begin
            busy <= 1'b1;
          end
          pwt_pkg::REQ_PERIOD: begin
            result_valid <= 1'b1;
            write_index  <= '0;
            held_count   <= '0;
            sent_count   <= '0;
            ramp_window  <= WIN_W'(1);
            worst_rtt    <= '0;
            cur_window   <= (grown > 32'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : WIN_W'(grown);
          end
          default: begin
            result_valid <= 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      window      <= cur_window;
      window_open <= (sent_next < CNT_W'(ramp_next));
      unacked     <= held_next;
      max_rtt     <= worst_next;
      report      <= 1'b0;
      ack_matched <= tok[STORE_DEPTH].found;
      overflow    <= 1'b0;
    end else if (accept) begin
      window      <= cur_window;
      unacked     <= held_count;
      max_rtt     <= worst_rtt;
      report      <= 1'b0;
      ack_matched <= 1'b0;
      overflow    <= 1'b0;
      window_open <= (sent_count < CNT_W'(ramp_window));
      case (req_type)
        pwt_pkg::REQ_SENT: begin
          overflow    <= full;
          unacked     <= full ? held_count : held_count + CNT_W'(1);
          window_open <= full ? (sent_count < CNT_W'(ramp_window))
                              : ((sent_count + CNT_W'(1)) < CNT_W'(ramp_window));
        end
        pwt_pkg::REQ_PERIOD: begin
          report      <= 1'b1;
          window_open <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(busy && result_valid))
    else $error("result strobed while ack scan in flight");

  assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type != pwt_pkg::REQ_ACK)) |=> result_valid)
    else $error("non-ack transaction gave no result");

  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(accept && (req_type == pwt_pkg::REQ_ACK)))
    else $error("scan started without ack transaction");

  assert property (@(posedge clk) disable iff (rst)
    scan_done |-> busy)
    else $error("scan token reached chain end while idle");

endmodule
`default_nettype wire
